// ===== design/ahvfp_pkg.sv =====
// ----------------------------------------------------------------------------
// ahvfp_pkg
// shared types and constants of the ascii hex vector frame parser
// ----------------------------------------------------------------------------
package ahvfp_pkg;

    localparam logic [4:0] POS_IDLE   = 5'd28;
    localparam logic [4:0] FRAME_LAST = 5'd27;
    localparam logic [4:0] FIRST_HEX  = 5'd3;

    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_STAR    = 8'h2A;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] character;
        logic       frame_start;
    } t_in;

    typedef struct packed {
        logic        frame_valid;
        logic [7:0]  sender_id;
        logic [7:0]  kind;
        logic [31:0] x_bits;
        logic [31:0] y_bits;
        logic [31:0] z_bits;
    } t_out;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_ID    = 3'd1,
        OP_KIND  = 3'd2,
        OP_HEX   = 3'd3,
        OP_END   = 3'd4
    } t_op;

    // one classified character on its way from front to back
    typedef struct packed {
        t_op        op;
        logic [4:0] pos;
        logic [7:0] val;
        logic       hex_ok;
    } t_tok;

endpackage

// ===== design/ahvfp_front.sv =====
// ----------------------------------------------------------------------------
// ahvfp_front
// tracks frame position and classifies each character into a token
// ----------------------------------------------------------------------------
module ahvfp_front
    import ahvfp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_tok_valid,
    input  logic i_tok_ready,
    output t_tok o_tok
);

    logic [4:0] r_pos;
    logic [4:0] n_pos;
    logic [4:0] cur_pos;
    logic       accept;
    logic       in_frame;
    logic [3:0] nib;
    logic       nib_ok;
    logic [7:0] c;

    assign c          = i_in.character;
    assign o_in_ready = i_tok_ready;
    assign accept     = i_in_valid && i_tok_ready;
    assign in_frame   = i_in.frame_start || (r_pos < POS_IDLE);
    assign cur_pos    = i_in.frame_start ? 5'd0 : r_pos;
    assign o_tok_valid = i_in_valid && in_frame;

    // hex digit decode
    always_comb begin
        nib    = 4'd0;
        nib_ok = 1'b0;
        if (c inside {[8'h30:8'h39]}) begin
            nib    = c[3:0];
            nib_ok = 1'b1;
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            nib    = c[3:0] + 4'd9;
            nib_ok = 1'b1;
        end
    end

    always_comb begin
        o_tok.pos    = cur_pos;
        o_tok.hex_ok = 1'b0;
        o_tok.val    = 8'd0;
        if (cur_pos == 5'd0) begin
            o_tok.op  = OP_START;
            o_tok.val = {7'd0, c == CH_HASH};
        end else if (cur_pos == 5'd1) begin
            o_tok.op  = OP_ID;
            o_tok.val = c - ASCII_ZERO;
        end else if (cur_pos == 5'd2) begin
            o_tok.op  = OP_KIND;
            o_tok.val = c - ASCII_ZERO;
        end else if (cur_pos < FRAME_LAST) begin
            o_tok.op     = OP_HEX;
            o_tok.val    = {4'd0, nib};
            o_tok.hex_ok = nib_ok;
        end else begin
            o_tok.op  = OP_END;
            o_tok.val = {7'd0, c == CH_STAR};
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (accept && in_frame) begin
            n_pos = (cur_pos == FRAME_LAST) ? POS_IDLE : cur_pos + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_IDLE;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// ===== design/ahvfp_queue.sv =====
// ----------------------------------------------------------------------------
// ahvfp_queue
// short token queue that decouples front and back
// ----------------------------------------------------------------------------
module ahvfp_queue
    import ahvfp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_tok i_push,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_tok o_pop
);

    t_tok              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop        = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/ahvfp_back.sv =====
// ----------------------------------------------------------------------------
// ahvfp_back
// assembles id, kind and words from tokens and registers the result
// ----------------------------------------------------------------------------
module ahvfp_back
    import ahvfp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_tok_valid,
    output logic o_tok_ready,
    input  t_tok i_tok,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    logic        r_start_seen;
    logic [7:0]  r_id;
    logic [7:0]  r_kind;
    logic [31:0] r_word [3];
    logic [3:0]  r_hi;
    logic        r_hi_ok;
    logic        r_out_valid;
    t_out        r_out;

    logic        out_free;
    logic        pop;
    logic [4:0]  off;
    logic [1:0]  widx;
    logic [7:0]  byte_val;
    logic [31:0] byte_shifted;
    logic        frame_ok;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_tok_ready = (i_tok.op != OP_END) || out_free;
    assign pop         = i_tok_valid && o_tok_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign off  = i_tok.pos - FIRST_HEX;
    assign widx = off[4:3];
    assign frame_ok = r_start_seen && i_tok.val[0];

    // strtol-like pair decode
    always_comb begin
        if (!r_hi_ok) begin
            byte_val = 8'd0;
        end else if (!i_tok.hex_ok) begin
            byte_val = {4'd0, r_hi};
        end else begin
            byte_val = {r_hi, i_tok.val[3:0]};
        end
        byte_shifted = {24'd0, byte_val} << {off[2:1], 3'b000};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_seen <= 1'b0;
            r_id         <= 8'd0;
            r_kind       <= 8'd0;
            r_word[0]    <= 32'd0;
            r_word[1]    <= 32'd0;
            r_word[2]    <= 32'd0;
            r_hi         <= 4'd0;
            r_hi_ok      <= 1'b0;
        end else if (pop) begin
            case (i_tok.op)
                OP_START: begin
                    r_start_seen <= i_tok.val[0];
                    r_id         <= 8'd0;
                    r_kind       <= 8'd0;
                    r_word[0]    <= 32'd0;
                    r_word[1]    <= 32'd0;
                    r_word[2]    <= 32'd0;
                    r_hi         <= 4'd0;
                    r_hi_ok      <= 1'b0;
                end
                OP_ID: begin
                    r_id <= i_tok.val;
                end
                OP_KIND: begin
                    r_kind <= i_tok.val;
                end
                OP_HEX: begin
                    if (!off[0]) begin
                        r_hi    <= i_tok.val[3:0];
                        r_hi_ok <= i_tok.hex_ok;
                    end else begin
                        r_word[widx] <= r_word[widx] | byte_shifted;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (pop && i_tok.op == OP_END) begin
            r_out.frame_valid <= frame_ok;
            r_out.sender_id   <= frame_ok ? r_id : 8'd0;
            r_out.kind        <= frame_ok ? r_kind : 8'd0;
            r_out.x_bits      <= frame_ok ? r_word[0] : 32'd0;
            r_out.y_bits      <= frame_ok ? r_word[1] : 32'd0;
            r_out.z_bits      <= frame_ok ? r_word[2] : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop && i_tok.op == OP_END) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

// ===== design/ascii_hex_vector_frame_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_hex_vector_frame_parser
// parses 28-character ascii frames carrying an id, a kind and three hex words
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready / i_in) takes one character item
//   per cycle; frame_start marks position 0 and always restarts the frame
//   output channel (o_out_valid / i_out_ready / o_out) gives one result item
//   per frame, on the character at position 27
// result path: the closing character's token goes through the token queue
//   and then the result register before the result shows
// throughput: one character per cycle while o_in_ready is high, set by the
//   front classifier and the back assembler each handling one token per cycle
// reset: position goes idle, the queue empties and no result is pending;
//   characters with frame_start low are then dropped until a frame starts
// receiver stall: the result waits in its register; the back keeps taking
//   non-final tokens, and the 4-entry queue fills before o_in_ready drops
// ----------------------------------------------------------------------------
module ascii_hex_vector_frame_parser
    import ahvfp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    // front to queue
    logic f_valid;
    logic f_ready;
    t_tok f_tok;
    // queue to back
    logic b_valid;
    logic b_ready;
    t_tok b_tok;

    // position tracking and character classification
    ahvfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_tok_valid (f_valid),
        .i_tok_ready (f_ready),
        .o_tok       (f_tok)
    );

    // decoupling queue
    ahvfp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push       (f_tok),
        .o_pop_valid  (b_valid),
        .i_pop_ready  (b_ready),
        .o_pop        (b_tok)
    );

    // field assembly and result register
    ahvfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (b_valid),
        .o_tok_ready (b_ready),
        .i_tok       (b_tok),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ===== design/ahvfp_checker.sv =====
// ----------------------------------------------------------------------------
// ahvfp_checker
// port-level checks on the frame parser, attached by bind
// ----------------------------------------------------------------------------
module ahvfp_checker
    import ahvfp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // an invalid frame carries all-zero fields
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.frame_valid |->
            o_out.sender_id == 8'd0 && o_out.kind == 8'd0 &&
            o_out.x_bits == 32'd0 && o_out.y_bits == 32'd0 &&
            o_out.z_bits == 32'd0)
        else $error("invalid frame with nonzero fields");

    // no result pending right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // a character item that is held off stays offered and unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in))
        else $error("character item changed while held off");

endmodule

bind ascii_hex_vector_frame_parser ahvfp_checker u_checker (.*);
